@@ rtl/sor_pkg.sv @@
// ----------------------------------------------------------------------------
// sor_pkg: shared types and constants of the sigma outlier rejector
// Field widths, datapath widths of the lane and merge stages, and the stage
// numbering that the pipeline control uses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sor_pkg;

    // Sensor set and field widths
    localparam int NUM_SENSORS = 4;
    localparam int VALUE_W     = 32;
    localparam int FACTOR_W    = 7;
    localparam int COUNT_W     = 3;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 7'd4;

    // Datapath widths
    localparam int SUM_W    = VALUE_W + 2;          // sum of four readings
    localparam int K_W      = 3;                    // active count 0..4
    localparam int D_W      = VALUE_W + 4;          // k*x - S with margin
    localparam int MAG_W    = VALUE_W + 3;          // |k*x - S|
    localparam int LO_W     = VALUE_W;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int PP_LL_W  = 2 * LO_W;
    localparam int PP_LH_W  = LO_W + HI_W;
    localparam int PP_HH_W  = 2 * HI_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUMSQ_W  = SQ_W + 2;
    localparam int LHS_W    = SQ_W + K_W;
    localparam int RHS_W    = SUMSQ_W + FACTOR_W;

    // Pipeline stages
    localparam int NUM_STAGES = 7;
    localparam int ST_SUM     = 0;  // sum and count of active readings
    localparam int ST_MAG     = 1;  // per-lane deviation magnitude
    localparam int ST_PP      = 2;  // partial products of the square
    localparam int ST_SQ      = 3;  // per-lane square
    localparam int ST_SUMSQ   = 4;  // sum of squares
    localparam int ST_MUL     = 5;  // scaled sides of the test
    localparam int ST_OUT     = 6;  // kept flags and count

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [K_W-1:0]            k_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [LHS_W-1:0]          lhs_t;

    // Load enables of the pipeline stages
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } stage_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/sor_lane.sv @@
// ----------------------------------------------------------------------------
// sor_lane: per-sensor deviation square
// Forms |k*x - S| for one reading and squares it from partial products over
// three stages. An inactive reading yields a zero square.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sor_lane (
    input  wire logic                 clk,
    input  wire sor_pkg::stage_ctrl_t ctrl,
    input  wire sor_pkg::value_t      x,
    input  wire logic                 act,
    input  wire sor_pkg::sum_t        sum,
    input  wire sor_pkg::k_t          k,
    output sor_pkg::sq_t              sq,
    output logic                      act_out
);

    localparam int VALUE_W = sor_pkg::VALUE_W;
    localparam int SUM_W   = sor_pkg::SUM_W;
    localparam int D_W     = sor_pkg::D_W;
    localparam int MAG_W   = sor_pkg::MAG_W;
    localparam int LO_W    = sor_pkg::LO_W;
    localparam int HI_W    = sor_pkg::HI_W;
    localparam int PP_LL_W = sor_pkg::PP_LL_W;
    localparam int PP_LH_W = sor_pkg::PP_LH_W;
    localparam int PP_HH_W = sor_pkg::PP_HH_W;
    localparam int SQ_W    = sor_pkg::SQ_W;

    logic signed [D_W-1:0] x_ext;
    logic signed [D_W-1:0] s_ext;
    logic signed [D_W-1:0] kx;
    logic signed [D_W-1:0] d;
    logic signed [D_W-1:0] neg_d;
    logic [MAG_W-1:0]      mag_next;
    logic [MAG_W-1:0]      mag_reg;
    logic                  act1_reg;

    logic [LO_W-1:0]       lo;
    logic [HI_W-1:0]       hi;
    logic [PP_LL_W-1:0]    pp_ll_next;
    logic [PP_LH_W-1:0]    pp_lh_next;
    logic [PP_HH_W-1:0]    pp_hh_next;
    logic [PP_LL_W-1:0]    pp_ll_reg;
    logic [PP_LH_W-1:0]    pp_lh_reg;
    logic [PP_HH_W-1:0]    pp_hh_reg;
    logic                  act2_reg;

    logic [SQ_W-1:0]       sq_next;
    logic [SQ_W-1:0]       sq_reg;
    logic                  act3_reg;

    // Form the deviation k*x - S by shift and add, take its magnitude
    always_comb
    begin
        x_ext = {{(D_W-VALUE_W){x[VALUE_W-1]}}, x};
        s_ext = {{(D_W-SUM_W){sum[SUM_W-1]}}, sum};
        kx    = '0;
        if (k[0])
        begin
            kx = kx + x_ext;
        end
        if (k[1])
        begin
            kx = kx + (x_ext <<< 1);
        end
        if (k[2])
        begin
            kx = kx + (x_ext <<< 2);
        end
        d     = kx - s_ext;
        neg_d = -d;
        if (!act)
        begin
            mag_next = '0;
        end
        else if (d[D_W-1])
        begin
            mag_next = neg_d[MAG_W-1:0];
        end
        else
        begin
            mag_next = d[MAG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_MAG])
        begin
            mag_reg  <= mag_next;
            act1_reg <= act;
        end
    end

    // Split the magnitude into low word and high bits, form partial products
    assign lo         = mag_reg[LO_W-1:0];
    assign hi         = mag_reg[MAG_W-1:LO_W];
    assign pp_ll_next = lo * lo;
    assign pp_lh_next = {{HI_W{1'b0}}, lo} * {{LO_W{1'b0}}, hi};
    assign pp_hh_next = {{HI_W{1'b0}}, hi} * {{HI_W{1'b0}}, hi};

    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_PP])
        begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hh_reg <= pp_hh_next;
            act2_reg  <= act1_reg;
        end
    end

    // Combine: lo^2 + 2*lo*hi*2^LO_W + hi^2*2^(2*LO_W)
    assign sq_next = {{(SQ_W-PP_LL_W){1'b0}}, pp_ll_reg}
                   + {{(SQ_W-PP_LH_W-LO_W-1){1'b0}}, pp_lh_reg, {(LO_W+1){1'b0}}}
                   + {pp_hh_reg, {(2*LO_W){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_SQ])
        begin
            sq_reg   <= sq_next;
            act3_reg <= act2_reg;
        end
    end

    assign sq      = sq_reg;
    assign act_out = act3_reg;

endmodule

`default_nettype wire

@@ rtl/sor_merge.sv @@
// ----------------------------------------------------------------------------
// sor_merge: combine lane squares and decide which readings to keep
// Sums the lane squares, scales both sides of the rejection test, compares
// each lane against the threshold and counts the kept readings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sor_merge (
    input  wire logic                                         clk,
    input  wire sor_pkg::stage_ctrl_t                         ctrl,
    input  wire sor_pkg::sq_t [sor_pkg::NUM_SENSORS-1:0]      sq,
    input  wire logic [sor_pkg::NUM_SENSORS-1:0]              act,
    input  wire sor_pkg::k_t                                  k,
    input  wire logic [sor_pkg::FACTOR_W-1:0]                 factor,
    output logic [sor_pkg::NUM_SENSORS-1:0]                   keep,
    output logic [sor_pkg::COUNT_W-1:0]                       kept_count
);

    localparam int NUM_SENSORS = sor_pkg::NUM_SENSORS;
    localparam int SQ_W        = sor_pkg::SQ_W;
    localparam int SUMSQ_W     = sor_pkg::SUMSQ_W;
    localparam int LHS_W       = sor_pkg::LHS_W;
    localparam int RHS_W       = sor_pkg::RHS_W;
    localparam int COUNT_W     = sor_pkg::COUNT_W;

    logic [SUMSQ_W-1:0]                     sumsq_next;
    logic [SUMSQ_W-1:0]                     sumsq_reg;
    sor_pkg::sq_t [NUM_SENSORS-1:0]         sq4_reg;
    logic [NUM_SENSORS-1:0]                 act4_reg;
    sor_pkg::k_t                            k4_reg;

    logic [RHS_W-1:0]                       rhs_next;
    logic [RHS_W-1:0]                       rhs_reg;
    sor_pkg::lhs_t [NUM_SENSORS-1:0]        lhs_next;
    sor_pkg::lhs_t [NUM_SENSORS-1:0]        lhs_reg;
    logic [NUM_SENSORS-1:0]                 act5_reg;

    logic [NUM_SENSORS-1:0]                 keep_next;
    logic [COUNT_W-1:0]                     count_next;
    logic [NUM_SENSORS-1:0]                 keep_reg;
    logic [COUNT_W-1:0]                     count_reg;

    // Sum the lane squares
    always_comb
    begin
        sumsq_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            sumsq_next = sumsq_next + {{(SUMSQ_W-SQ_W){1'b0}}, sq[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_SUMSQ])
        begin
            sumsq_reg <= sumsq_next;
            sq4_reg   <= sq;
            act4_reg  <= act;
            k4_reg    <= k;
        end
    end

    // Scale: factor * sum of squares, k * own square
    always_comb
    begin
        rhs_next = {{(RHS_W-sor_pkg::FACTOR_W){1'b0}}, factor}
                 * {{(RHS_W-SUMSQ_W){1'b0}}, sumsq_reg};
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            lhs_next[i] = '0;
            if (k4_reg[0])
            begin
                lhs_next[i] = lhs_next[i] + {{(LHS_W-SQ_W){1'b0}}, sq4_reg[i]};
            end
            if (k4_reg[1])
            begin
                lhs_next[i] = lhs_next[i] + {{(LHS_W-SQ_W-1){1'b0}}, sq4_reg[i], 1'b0};
            end
            if (k4_reg[2])
            begin
                lhs_next[i] = lhs_next[i] + {{(LHS_W-SQ_W-2){1'b0}}, sq4_reg[i], 2'b00};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_MUL])
        begin
            rhs_reg  <= rhs_next;
            lhs_reg  <= lhs_next;
            act5_reg <= act4_reg;
        end
    end

    // Keep an active reading unless its scaled square exceeds the threshold, count the kept ones
    always_comb
    begin
        count_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            keep_next[i] = act5_reg[i]
                && !({{(RHS_W-LHS_W){1'b0}}, lhs_reg[i]} > rhs_reg);
            count_next   = count_next + {{(COUNT_W-1){1'b0}}, keep_next[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_OUT])
        begin
            keep_reg  <= keep_next;
            count_reg <= count_next;
        end
    end

    assign keep       = keep_reg;
    assign kept_count = count_reg;

endmodule

`default_nettype wire

@@ rtl/sigma_outlier_rejector_top.sv @@
// ----------------------------------------------------------------------------
// sigma_outlier_rejector_top: outlier rejection over redundant sensors
// Seven-stage pipeline: the input sum stage, then the lane and merge stages.
// Throughput: one beat per cycle; a stalled output holds the pipeline only as
// far as bubbles are used up.
// Reset: clears all stage valid flags and sets the factor register to 4.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sigma_outlier_rejector_top #(
    parameter int LANES = 4
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [sor_pkg::VALUE_W-1:0]  value_0,
    input  wire logic signed [sor_pkg::VALUE_W-1:0]  value_1,
    input  wire logic signed [sor_pkg::VALUE_W-1:0]  value_2,
    input  wire logic signed [sor_pkg::VALUE_W-1:0]  value_3,
    input  wire logic                                active_0,
    input  wire logic                                active_1,
    input  wire logic                                active_2,
    input  wire logic                                active_3,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     keep_0,
    output logic                                     keep_1,
    output logic                                     keep_2,
    output logic                                     keep_3,
    output logic [sor_pkg::COUNT_W-1:0]              kept_count,
    input  wire logic                                cfg_we,
    input  wire logic [sor_pkg::FACTOR_W-1:0]        cfg_wdata
);

    localparam int NUM_SENSORS = sor_pkg::NUM_SENSORS;
    localparam int NUM_STAGES  = sor_pkg::NUM_STAGES;
    localparam int VALUE_W     = sor_pkg::VALUE_W;
    localparam int SUM_W       = sor_pkg::SUM_W;
    localparam int K_W         = sor_pkg::K_W;

    logic [sor_pkg::FACTOR_W-1:0]            factor_reg;
    logic [NUM_STAGES-1:0]                   valid_reg;
    logic [NUM_STAGES-1:0]                   valid_next;
    sor_pkg::stage_ctrl_t                    ctrl;

    sor_pkg::value_t [NUM_SENSORS-1:0]       x_in;
    logic [NUM_SENSORS-1:0]                  act_in;
    sor_pkg::sum_t                           s_next;
    sor_pkg::k_t                             k_next;

    sor_pkg::value_t [NUM_SENSORS-1:0]       x_reg;
    logic [NUM_SENSORS-1:0]                  act_reg;
    sor_pkg::sum_t                           s_reg;
    sor_pkg::k_t                             k_reg;
    sor_pkg::k_t                             k1_reg;
    sor_pkg::k_t                             k2_reg;
    sor_pkg::k_t                             k3_reg;

    sor_pkg::sq_t [NUM_SENSORS-1:0]          lane_sq;
    logic [NUM_SENSORS-1:0]                  lane_act;
    logic [NUM_SENSORS-1:0]                  keep;

    // Hold the threshold factor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= sor_pkg::FACTOR_RESET;
        end
        else if (cfg_we)
        begin
            factor_reg <= cfg_wdata;
        end
    end

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        ctrl.en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ctrl.en[i] = !valid_reg[i] || ctrl.en[i+1];
        end
        valid_next = valid_reg;
        if (ctrl.en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (ctrl.en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = ctrl.en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Gather the input beat, drop lanes beyond the configured count
    assign x_in = {value_3, value_2, value_1, value_0};

    always_comb
    begin
        act_in = {active_3, active_2, active_1, active_0};
        s_next = '0;
        k_next = '0;
        for (int i = 0; i < NUM_SENSORS; i++)
        begin
            act_in[i] = act_in[i] && (i < LANES);
            if (act_in[i])
            begin
                s_next = s_next + {{(SUM_W-VALUE_W){x_in[i][VALUE_W-1]}}, x_in[i]};
                k_next = k_next + {{(K_W-1){1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_SUM])
        begin
            x_reg   <= x_in;
            act_reg <= act_in;
            s_reg   <= s_next;
            k_reg   <= k_next;
        end
    end

    // Carry the active count alongside the lanes
    always_ff @(posedge clk)
    begin
        if (ctrl.en[sor_pkg::ST_MAG])
        begin
            k1_reg <= k_reg;
        end
        if (ctrl.en[sor_pkg::ST_PP])
        begin
            k2_reg <= k1_reg;
        end
        if (ctrl.en[sor_pkg::ST_SQ])
        begin
            k3_reg <= k2_reg;
        end
    end

    // Lanes
    for (genvar g = 0; g < NUM_SENSORS; g++)
    begin : gen_lane
        if (g < LANES)
        begin : gen_active
            sor_lane u_lane (
                .clk     (clk),
                .ctrl    (ctrl),
                .x       (x_reg[g]),
                .act     (act_reg[g]),
                .sum     (s_reg),
                .k       (k_reg),
                .sq      (lane_sq[g]),
                .act_out (lane_act[g])
            );
        end
        else
        begin : gen_absent
            assign lane_sq[g]  = '0;
            assign lane_act[g] = 1'b0;
        end
    end

    // Merge
    sor_merge u_merge (
        .clk        (clk),
        .ctrl       (ctrl),
        .sq         (lane_sq),
        .act        (lane_act),
        .k          (k3_reg),
        .factor     (factor_reg),
        .keep       (keep),
        .kept_count (kept_count)
    );

    assign keep_0 = keep[0];
    assign keep_1 = keep[1];
    assign keep_2 = keep[2];
    assign keep_3 = keep[3];

    // Checks
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kept_count == $countones(keep)))
        else $error("kept_count disagrees with keep flags");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kept_count <= LANES))
        else $error("kept_count exceeds lane count");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[sor_pkg::ST_SUM])
        else $error("accepted beat not captured");

endmodule

`default_nettype wire

@@ test/tb_sigma_outlier_rejector_top.sv @@
// ----------------------------------------------------------------------------
// tb_sigma_outlier_rejector_top: self-checking bench of the outlier rejector
// Drives sets of four sensor readings through the valid/ready input, screens
// each accepted set that has no hand-written verdict with an integer model of
// the sigma test, and compares the kept flags and count of every output beat in order. A short table of
// directed sets comes first, then random phases, each under its own factor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sigma_outlier_rejector_top;

    typedef sor_pkg::value_t value_t;
    typedef logic [sor_pkg::FACTOR_W-1:0] factor_t;

    localparam value_t VMAX = 32'sh7FFF_FFFF;
    localparam value_t VMIN = 32'sh8000_0000;
    localparam int PHASES = 10;
    localparam int PHASE_BEATS = 185;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        value_t     value [4];
        logic [3:0] active;
    } reading_t;

    typedef struct packed {
        logic [3:0]                  keep;
        logic [sor_pkg::COUNT_W-1:0] count;
    } verdict_t;

    typedef struct {
        factor_t  factor;
        reading_t reading;
        bit       typed;
        verdict_t verdict;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    value_t value_0 = '0;
    value_t value_1 = '0;
    value_t value_2 = '0;
    value_t value_3 = '0;
    logic active_0 = 1'b0;
    logic active_1 = 1'b0;
    logic active_2 = 1'b0;
    logic active_3 = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic keep_0;
    logic keep_1;
    logic keep_2;
    logic keep_3;
    logic [sor_pkg::COUNT_W-1:0] kept_count;
    logic cfg_we = 1'b0;
    factor_t cfg_wdata = '0;

    factor_t factor_setting = sor_pkg::FACTOR_RESET;
    verdict_t pending_verdicts [$];
    plan_row_t plan [$];
    int mismatch_count = 0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;

    sigma_outlier_rejector_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_0    (value_0),
        .value_1    (value_1),
        .value_2    (value_2),
        .value_3    (value_3),
        .active_0   (active_0),
        .active_1   (active_1),
        .active_2   (active_2),
        .active_3   (active_3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .keep_0     (keep_0),
        .keep_1     (keep_1),
        .keep_2     (keep_2),
        .keep_3     (keep_3),
        .kept_count (kept_count),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Screen one set: reject x when k*(k*x - S)^2 > factor * sum of (k*xi - S)^2
    function automatic verdict_t screen_readings(reading_t r, factor_t factor);
        verdict_t v;
        longint total;
        longint n;
        longint dev;
        logic [63:0] mag;
        logic [127:0] sq [4];
        logic [127:0] sumsq;
        logic [127:0] bound;
        logic [127:0] lhs;
        total = 0;
        n = 0;
        sumsq = '0;
        v = '0;
        for (int i = 0; i < 4; i++) begin
            if (r.active[i]) begin
                total += longint'(r.value[i]);
                n++;
            end
        end
        for (int i = 0; i < 4; i++) begin
            sq[i] = '0;
            if (r.active[i]) begin
                dev = n * longint'(r.value[i]) - total;
                mag = (dev < 0) ? -dev : dev;
                sq[i] = 128'(mag) * 128'(mag);
                sumsq += sq[i];
            end
        end
        bound = sumsq * 128'(factor);
        for (int i = 0; i < 4; i++) begin
            if (r.active[i]) begin
                lhs = sq[i] * 128'(n);
                if (lhs <= bound) begin
                    v.keep[i] = 1'b1;
                    v.count++;
                end
            end
        end
        return v;
    endfunction

    // Mostly tight clusters with an occasional stray lane, plus raw, extreme and all-equal sets
    function automatic reading_t random_reading();
        reading_t r;
        value_t base;
        value_t off;
        int unsigned spread;
        int shape;
        int lane;
        shape = $urandom_range(0, 9);
        base = $urandom;
        spread = 32'd1 << $urandom_range(0, 20);
        for (int i = 0; i < 4; i++) begin
            if (shape <= 5)
                r.value[i] = base + value_t'($urandom_range(0, spread));
            else if (shape <= 7)
                r.value[i] = $urandom;
            else if (shape == 8) begin
                case ($urandom_range(0, 4))
                    0: r.value[i] = VMIN;
                    1: r.value[i] = VMAX;
                    2: r.value[i] = 0;
                    3: r.value[i] = -1;
                    default: r.value[i] = 1;
                endcase
            end
            else
                r.value[i] = base;
        end
        if (shape <= 5 && $urandom_range(0, 1) == 1) begin
            lane = $urandom_range(0, 3);
            off = value_t'($urandom_range(0, 4 * spread));
            r.value[lane] = $urandom_range(0, 1) ? base + off : base - off;
        end
        r.active = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'b1111;
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones; none when steady
    function automatic int pick_gap(bit steady, int longest);
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, longest);
    endfunction

    task automatic log_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic add_row(factor_t factor, value_t v0, value_t v1, value_t v2,
                           value_t v3, logic [3:0] active, bit typed,
                           logic [3:0] keep, logic [2:0] count);
        plan_row_t row;
        row.factor = factor;
        row.reading.value[0] = v0;
        row.reading.value[1] = v1;
        row.reading.value[2] = v2;
        row.reading.value[3] = v3;
        row.reading.active = active;
        row.typed = typed;
        row.verdict.keep = keep;
        row.verdict.count = count;
        plan.push_back(row);
    endtask

    // Present one set, hold it until accepted, then queue its verdict
    task automatic send_reading(reading_t r, bit typed, verdict_t verdict);
        int gap;
        gap = pick_gap(in_steady, 30);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value_0 <= r.value[0];
        value_1 <= r.value[1];
        value_2 <= r.value[2];
        value_3 <= r.value[3];
        active_0 <= r.active[0];
        active_1 <= r.active[1];
        active_2 <= r.active[2];
        active_3 <= r.active[3];
        do @(posedge clk); while (!in_ready);
        pending_verdicts.push_back(typed ? verdict : screen_readings(r, factor_setting));
    endtask

    // Drop valid and wait until every queued verdict has come out
    task automatic settle_input();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_factor(factor_t factor);
        cfg_we <= 1'b1;
        cfg_wdata <= factor;
        @(posedge clk);
        cfg_we <= 1'b0;
        factor_setting = factor;
    endtask

    // Output side: check each accepted beat, then pick the next ready level
    initial
    begin : result_side
        int stall_left;
        verdict_t got;
        verdict_t want;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                got.keep = {keep_3, keep_2, keep_1, keep_0};
                got.count = kept_count;
                if (pending_verdicts.size() == 0)
                    log_mismatch($sformatf("beat with nothing expected: keep %b count %0d",
                                           got.keep, got.count));
                else begin
                    want = pending_verdicts.pop_front();
                    if (got.keep !== want.keep || got.count !== want.count)
                        log_mismatch($sformatf("keep exp %b got %b, count exp %0d got %0d",
                                               want.keep, got.keep, want.count, got.count));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else
                stall_left = pick_gap(out_steady, 40);
            out_ready <= (stall_left == 0);
        end
    end

    initial
    begin : stimulus
        factor_t phase_factor;
        reading_t r;
        // Directed sets; active and keep columns read lane 3 down to lane 0
        add_row(4, VMAX, VMIN, -1, 1, 4'b0000, 1, 4'b0000, 0);      // nothing active
        add_row(4, 5, 9, VMIN, 3, 4'b0100, 1, 4'b0100, 1);          // lone lane
        add_row(4, VMAX, VMAX, VMAX, VMAX, 4'b1111, 1, 4'b1111, 4); // all equal
        add_row(4, VMIN, VMIN, VMIN, VMIN, 4'b1111, 1, 4'b1111, 4);
        add_row(4, VMAX, VMIN, VMAX, VMIN, 4'b1111, 0, 4'b0000, 0);
        add_row(4, 0, 0, 0, 1000, 4'b1111, 0, 4'b0000, 0);
        add_row(4, 5, 0, 0, -5, 4'b1001, 0, 4'b0000, 0);
        add_row(1, 0, 0, 0, 1000, 4'b1111, 0, 4'b0000, 0);
        add_row(1, VMAX, VMIN, 0, 0, 4'b0111, 0, 4'b0000, 0);
        add_row(1, 0, -7, 11, 0, 4'b0110, 0, 4'b0000, 0);          // test sits on equality
        add_row(2, 0, 0, 0, 1000, 4'b1111, 0, 4'b0000, 0);
        add_row(0, 1, 2, 3, 4, 4'b1111, 1, 4'b0000, 0);             // zero factor drops all
        add_row(0, 7, 7, 7, 7, 4'b1111, 1, 4'b1111, 4);
        add_row(0, 3, 3, 3, VMIN, 4'b1000, 1, 4'b1000, 1);
        add_row(127, VMIN, VMAX, VMIN, VMAX, 4'b1111, 0, 4'b0000, 0);
        add_row(127, VMIN, VMIN, VMIN, VMAX, 4'b1111, 0, 4'b0000, 0);
        add_row(64, 0, 0, 0, -1, 4'b1111, 0, 4'b0000, 0);

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table, reprogramming the factor only while idle
        foreach (plan[i]) begin
            if (plan[i].factor != factor_setting) begin
                settle_input();
                write_factor(plan[i].factor);
            end
            send_reading(plan[i].reading, plan[i].typed, plan[i].verdict);
        end

        // Random phases: fixed extremes first, then factors biased to the low end
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: phase_factor = 4;
                1: phase_factor = 1;
                2: phase_factor = 2;
                3: phase_factor = 0;
                4: phase_factor = 127;
                5: phase_factor = 64;
                default: phase_factor = ($urandom_range(0, 3) != 0) ?
                                        factor_t'($urandom_range(0, 3)) :
                                        factor_t'($urandom_range(0, 127));
            endcase
            settle_input();
            write_factor(phase_factor);
            in_steady = (phase % 4 == 1);
            out_steady = (phase % 3 == 2);
            repeat (PHASE_BEATS) begin
                r = random_reading();
                send_reading(r, 1'b0, '0);
            end
        end

        // Drain, then give stray beats a chance to show up
        settle_input();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
